FILE: hw/rtl/ert_pkg.sv
// Shared types and constants for the entity range query table.
package ert_pkg;

    localparam int OP_W   = 3;
    localparam int SLOT_W = 6;
    localparam int EXT_W  = 23;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_op OP_ADD    = 3'd0;
    localparam t_op OP_REMOVE = 3'd1;
    localparam t_op OP_MOVE   = 3'd2;
    localparam t_op OP_RECT   = 3'd3;
    localparam t_op OP_CIRCLE = 3'd4;
    localparam t_op OP_CYL    = 3'd5;
    localparam t_op OP_CUBOID = 3'd6;

    // Tag that travels with each slot read through the match pipeline.
    typedef struct packed {
        logic  vld;
        logic  ent;
        t_slot slot;
        logic  last;
    } t_tag;

    // Verdict for one scanned slot.
    typedef struct packed {
        logic  vld;
        logic  hit;
        t_slot slot;
        logic  last;
    } t_hit;

endpackage

FILE: hw/rtl/ert_pos_mem.sv
// Position memory: one write port, one read port with registered data.
module ert_pos_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ert_match.sv
// Three-stage match pipeline: absolute differences, squares and compares, verdict.
module ert_match #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ert_pkg::t_tag                i_tag,
    input  logic signed [COORD_BITS-1:0] i_ent_x,
    input  logic signed [COORD_BITS-1:0] i_ent_y,
    input  logic signed [COORD_BITS-1:0] i_ent_z,
    input  logic signed [COORD_BITS-1:0] i_cen_x,
    input  logic signed [COORD_BITS-1:0] i_cen_y,
    input  logic signed [COORD_BITS-1:0] i_cen_z,
    input  logic [ert_pkg::EXT_W-1:0]    i_ext_a,
    input  logic [ert_pkg::EXT_W-1:0]    i_ext_b,
    input  logic [ert_pkg::EXT_W-1:0]    i_ext_c,
    input  ert_pkg::t_op                 i_op,
    output ert_pkg::t_hit                o_hit
);

    localparam int AW   = COORD_BITS + 1;
    localparam int CW   = (AW > ert_pkg::EXT_W) ? AW : ert_pkg::EXT_W;
    localparam int SQ_W = 2 * ert_pkg::EXT_W;

    logic signed [AW-1:0]       dx, dy, dz;
    logic [AW-1:0]              ax, ay, az;
    logic [CW-1:0]              cx_abs, cy_abs, cz_abs;
    logic [ert_pkg::EXT_W-1:0]  tx, tz;
    logic [SQ_W:0]              sum_sq;
    logic                       hit;

    ert_pkg::t_tag              r_tag1, r_tag2;
    logic [AW-1:0]              r_ax, r_ay, r_az;
    logic [SQ_W-1:0]            r_sq_x, r_sq_z, r_sq_a;
    logic                       r_xa, r_zb, r_za, r_yb, r_yc;
    ert_pkg::t_hit              r_hit;

    // Stage 1: absolute differences, center minus stored.
    always_comb begin
        dx = AW'(i_cen_x) - AW'(i_ent_x);
        dy = AW'(i_cen_y) - AW'(i_ent_y);
        dz = AW'(i_cen_z) - AW'(i_ent_z);
        ax = dx[AW-1] ? AW'(-dx) : AW'(dx);
        ay = dy[AW-1] ? AW'(-dy) : AW'(dy);
        az = dz[AW-1] ? AW'(-dz) : AW'(dz);
    end

    // Stage 2 inputs: common compare width; squares use the low bits, which are
    // exact whenever the difference is within the radius.
    always_comb begin
        cx_abs = CW'(r_ax);
        cy_abs = CW'(r_ay);
        cz_abs = CW'(r_az);
        tx     = cx_abs[ert_pkg::EXT_W-1:0];
        tz     = cz_abs[ert_pkg::EXT_W-1:0];
    end

    // Stage 3: combine the tests of the query kind.
    always_comb begin
        sum_sq = (SQ_W+1)'(r_sq_x) + (SQ_W+1)'(r_sq_z);
        case (i_op)
            ert_pkg::OP_RECT:   hit = r_xa && r_zb;
            ert_pkg::OP_CUBOID: hit = r_xa && r_zb && r_yc;
            ert_pkg::OP_CIRCLE: hit = r_xa && r_za && (sum_sq <= (SQ_W+1)'(r_sq_a));
            ert_pkg::OP_CYL:    hit = r_xa && r_za && (sum_sq <= (SQ_W+1)'(r_sq_a)) && r_yb;
            default:            hit = 1'b0;
        endcase
        hit = hit && r_tag2.ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_hit  <= '0;
        end else begin
            r_tag1    <= i_tag;
            r_tag2    <= r_tag1;
            r_hit.vld  <= r_tag2.vld;
            r_hit.hit  <= hit;
            r_hit.slot <= r_tag2.slot;
            r_hit.last <= r_tag2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax   <= ax;
        r_ay   <= ay;
        r_az   <= az;
        r_xa   <= cx_abs <= CW'(i_ext_a);
        r_za   <= cz_abs <= CW'(i_ext_a);
        r_zb   <= cz_abs <= CW'(i_ext_b);
        r_yb   <= cy_abs <= CW'(i_ext_b);
        r_yc   <= cy_abs <= CW'(i_ext_c);
        r_sq_x <= SQ_W'(tx * tx);
        r_sq_z <= SQ_W'(tz * tz);
        r_sq_a <= SQ_W'(i_ext_a * i_ext_a);
    end

    assign o_hit = r_hit;

endmodule

FILE: hw/rtl/entity_range_query_table.sv
// Top level of the entity range query table: slot flags, scan sequencer, result emission.
//
// The block holds SLOTS entity slots, each a valid flag (cleared at reset) and an x, y, z
// position in signed Q16.8 kept in a single-port-read position memory. A transaction is
// accepted on a clock edge where i_start is high and o_busy is low. Add, remove and move
// complete at that edge, raise no busy and emit nothing, so they may be issued every cycle;
// a slot at or above SLOTS, or opcode 7, is dropped. A query (rectangle, circle, cylinder,
// cuboid) holds o_busy through the scan, in which the position memory delivers one slot per
// cycle, then while the memory read register and the three-stage match pipeline drain, and
// through a final flush state that releases the last result. Results come out in slot
// order, each on o_valid for exactly one cycle; the receiver cannot stall them and must take
// every strobe. o_last marks the final result of a query. A query with no match gives one
// result with o_found low, o_match_slot zero and o_last high. The final result shows up in
// the cycle o_busy drops, so the next transaction is accepted at the edge ending that cycle.
module entity_range_query_table #(
    parameter int SLOTS      = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [ert_pkg::OP_W-1:0]     i_op,
    input  logic [ert_pkg::SLOT_W-1:0]   i_slot,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic [ert_pkg::EXT_W-1:0]    i_extent_a,
    input  logic [ert_pkg::EXT_W-1:0]    i_extent_b,
    input  logic [ert_pkg::EXT_W-1:0]    i_extent_c,
    output logic                         o_valid,
    output logic                         o_found,
    output logic [ert_pkg::SLOT_W-1:0]   o_match_slot,
    output logic                         o_last
);

    localparam int IW    = $clog2(SLOTS);
    localparam int PW    = 3 * COORD_BITS;
    localparam int IDX_W = ert_pkg::SLOT_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

    t_state                       r_state;
    logic [SLOTS-1:0]             r_valid;
    logic [IW-1:0]                r_addr;
    ert_pkg::t_tag                r_tag;
    ert_pkg::t_op                 r_op;
    logic signed [COORD_BITS-1:0] r_cen_x, r_cen_y, r_cen_z;
    logic [ert_pkg::EXT_W-1:0]    r_ext_a, r_ext_b, r_ext_c;
    logic                         r_pend_vld;
    ert_pkg::t_slot               r_pend_slot;
    logic                         r_out_valid, r_found, r_last;
    ert_pkg::t_slot               r_out_slot;

    logic                         accept;
    logic                         slot_ok;
    logic                         is_query;
    logic                         mem_we;
    logic                         scan_rd;
    logic [PW-1:0]                rd_data;
    ert_pkg::t_hit                hit;

    assign o_busy   = (r_state != ST_IDLE);
    assign accept   = i_start && !o_busy;
    assign slot_ok  = ({1'b0, i_slot} < IDX_W'(SLOTS));
    assign is_query = (i_op == ert_pkg::OP_RECT) || (i_op == ert_pkg::OP_CIRCLE) ||
                      (i_op == ert_pkg::OP_CYL)  || (i_op == ert_pkg::OP_CUBOID);
    // Add and move write the position at the accept edge.
    assign mem_we   = accept && slot_ok &&
                      ((i_op == ert_pkg::OP_ADD) || (i_op == ert_pkg::OP_MOVE));
    assign scan_rd  = (r_state == ST_SCAN);

    ert_pos_mem #(
        .DEPTH (SLOTS),
        .WIDTH (PW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_slot[IW-1:0]),
        .i_wdata ({i_pos_x, i_pos_y, i_pos_z}),
        .i_re    (scan_rd),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    ert_match #(
        .COORD_BITS (COORD_BITS)
    ) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag),
        .i_ent_x (rd_data[3*COORD_BITS-1:2*COORD_BITS]),
        .i_ent_y (rd_data[2*COORD_BITS-1:COORD_BITS]),
        .i_ent_z (rd_data[COORD_BITS-1:0]),
        .i_cen_x (r_cen_x),
        .i_cen_y (r_cen_y),
        .i_cen_z (r_cen_z),
        .i_ext_a (r_ext_a),
        .i_ext_b (r_ext_b),
        .i_ext_c (r_ext_c),
        .i_op    (r_op),
        .o_hit   (hit)
    );

    // Slot flags: add sets, remove clears, both at the accept edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (accept && slot_ok) begin
            if (i_op == ert_pkg::OP_ADD) begin
                r_valid[i_slot[IW-1:0]] <= 1'b1;
            end else if (i_op == ert_pkg::OP_REMOVE) begin
                r_valid[i_slot[IW-1:0]] <= 1'b0;
            end
        end
    end

    // Latch the query; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept && is_query) begin
            r_op    <= i_op;
            r_cen_x <= i_pos_x;
            r_cen_y <= i_pos_y;
            r_cen_z <= i_pos_z;
            r_ext_a <= i_extent_a;
            r_ext_b <= i_extent_b;
            r_ext_c <= i_extent_c;
        end
    end

    // Sequencer and result registers. A match is held back one step so the final
    // one can carry the last flag; the flush cycle releases it or reports no match.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_tag       <= '0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_tag       <= '0;
            case (r_state)
                ST_IDLE: begin
                    if (accept && is_query) begin
                        r_state    <= ST_SCAN;
                        r_addr     <= '0;
                        r_pend_vld <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    r_tag.vld  <= 1'b1;
                    r_tag.ent  <= r_valid[r_addr];
                    r_tag.slot <= ert_pkg::SLOT_W'(r_addr);
                    r_tag.last <= (r_addr == IW'(SLOTS - 1));
                    if (r_addr == IW'(SLOTS - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (hit.vld && hit.last) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    r_out_valid <= 1'b1;
                    r_found     <= r_pend_vld;
                    r_out_slot  <= r_pend_vld ? r_pend_slot : '0;
                    r_last      <= 1'b1;
                    r_pend_vld  <= 1'b0;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (hit.vld && hit.hit) begin
                r_pend_vld  <= 1'b1;
                r_pend_slot <= hit.slot;
                if (r_pend_vld) begin
                    r_out_valid <= 1'b1;
                    r_found     <= 1'b1;
                    r_out_slot  <= r_pend_slot;
                    r_last      <= 1'b0;
                end
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_found;
    assign o_match_slot = r_out_slot;
    assign o_last       = r_last;

endmodule

FILE: hw/rtl/ert_checker.sv
// Port-level checks for the entity range query table, bound to the top level.
module ert_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_start,
    input logic                       o_busy,
    input logic [ert_pkg::OP_W-1:0]   i_op,
    input logic                       o_valid,
    input logic                       o_found,
    input logic [ert_pkg::SLOT_W-1:0] o_match_slot,
    input logic                       o_last
);

    // Raise busy in the cycle after a query is accepted.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == ert_pkg::OP_RECT || i_op == ert_pkg::OP_CIRCLE ||
         i_op == ert_pkg::OP_CYL || i_op == ert_pkg::OP_CUBOID)) |=> o_busy)
        else $error("query accepted but busy not raised");

    // Drop busy only together with the final result of the query.
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> (o_valid && o_last))
        else $error("busy fell without a final result");

    // Emit non-final results only while busy, and only for a found slot.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_busy && o_found))
        else $error("intermediate result outside a query");

    // A no-match result stands alone and names slot zero.
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_last && (o_match_slot == '0)))
        else $error("malformed no-match result");

    // Nothing follows a final result in the next cycle.
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result after the final one");

endmodule

bind entity_range_query_table ert_checker u_ert_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .i_op         (i_op),
    .o_valid      (o_valid),
    .o_found      (o_found),
    .o_match_slot (o_match_slot),
    .o_last       (o_last)
);

FILE: dv/ert_query_checker.sv
// Checker for the entity range query table: slot-table predictor and result compare.
`timescale 1ns / 1ps

module ert_query_checker #(
    parameter int SLOTS      = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  ert_pkg::t_op                  i_op,
    input  ert_pkg::t_slot                i_slot,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    input  logic signed [COORD_BITS-1:0]  i_pos_z,
    input  logic [ert_pkg::EXT_W-1:0]     i_extent_a,
    input  logic [ert_pkg::EXT_W-1:0]     i_extent_b,
    input  logic [ert_pkg::EXT_W-1:0]     i_extent_c,
    input  logic                          i_valid,
    input  logic                          i_found,
    input  ert_pkg::t_slot                i_match_slot,
    input  logic                          i_last,
    output int                            o_mismatches,
    output int                            o_pending
);

    typedef struct packed {
        logic           found;
        ert_pkg::t_slot slot;
        logic           last;
    } t_match;

    bit                           slot_live [SLOTS];
    logic signed [COORD_BITS-1:0] slot_x   [SLOTS];
    logic signed [COORD_BITS-1:0] slot_y   [SLOTS];
    logic signed [COORD_BITS-1:0] slot_z   [SLOTS];
    t_match                       pending_matches [$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
        o_mismatches++;
    endtask

    function automatic longint abs_gap(input longint p, input longint q);
        return (p > q) ? p - q : q - p;
    endfunction

    // Apply one accepted transaction to the slot table; queue the matches of a query.
    task automatic track_transaction();
        longint ax, ay, az;
        longint ea, eb, ec;
        bit     hit;
        int     hits;
        t_match rec;
        ea   = longint'(i_extent_a);
        eb   = longint'(i_extent_b);
        ec   = longint'(i_extent_c);
        hits = 0;
        case (i_op)
            ert_pkg::OP_ADD, ert_pkg::OP_MOVE: begin
                if (int'(i_slot) < SLOTS) begin
                    slot_x[i_slot] = i_pos_x;
                    slot_y[i_slot] = i_pos_y;
                    slot_z[i_slot] = i_pos_z;
                    if (i_op == ert_pkg::OP_ADD)
                        slot_live[i_slot] = 1'b1;
                end
            end
            ert_pkg::OP_REMOVE: begin
                if (int'(i_slot) < SLOTS)
                    slot_live[i_slot] = 1'b0;
            end
            ert_pkg::OP_RECT, ert_pkg::OP_CIRCLE, ert_pkg::OP_CYL, ert_pkg::OP_CUBOID: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (slot_live[s]) begin
                        ax = abs_gap(longint'(i_pos_x), longint'(slot_x[s]));
                        ay = abs_gap(longint'(i_pos_y), longint'(slot_y[s]));
                        az = abs_gap(longint'(i_pos_z), longint'(slot_z[s]));
                        if (i_op == ert_pkg::OP_RECT || i_op == ert_pkg::OP_CUBOID) begin
                            hit = (ax <= ea) && (az <= eb);
                            if (i_op == ert_pkg::OP_CUBOID && ay > ec)
                                hit = 1'b0;
                        end else begin
                            // bound each axis first so the squares cannot overflow
                            hit = (ax <= ea) && (az <= ea) && (ax * ax + az * az <= ea * ea);
                            if (i_op == ert_pkg::OP_CYL && ay > eb)
                                hit = 1'b0;
                        end
                        if (hit) begin
                            rec.found = 1'b1;
                            rec.slot  = ert_pkg::t_slot'(s);
                            rec.last  = 1'b0;
                            pending_matches = {pending_matches, rec};
                            hits++;
                        end
                    end
                end
                if (hits == 0) begin
                    rec.found = 1'b0;
                    rec.slot  = '0;
                    rec.last  = 1'b1;
                    pending_matches = {pending_matches, rec};
                end else begin
                    pending_matches[pending_matches.size()-1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_match want;
        if (!i_rst_n) begin
            foreach (slot_live[s])
                slot_live[s] = 1'b0;
            pending_matches.delete();
        end else begin
            // retire the result first; a new query never produces in its accept cycle
            if (i_valid) begin
                if (pending_matches.size() == 0) begin
                    report_mismatch("result with none pending, match_slot", i_match_slot, 0);
                end else begin
                    want = pending_matches.pop_front();
                    if (i_found !== want.found)
                        report_mismatch("found", i_found, want.found);
                    if (i_match_slot !== want.slot)
                        report_mismatch("match_slot", i_match_slot, want.slot);
                    if (i_last !== want.last)
                        report_mismatch("last", i_last, want.last);
                end
            end
            if (i_start && !i_busy)
                track_transaction();
        end
        o_pending = pending_matches.size();
    end

endmodule

FILE: dv/tb.sv
// Testbench top for the entity range query table: stimulus, checker hookup, verdict.
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS      = 64;
    localparam int COORD_BITS = 24;
    localparam int ITEM_COUNT = 400;

    // Opcode the block drops without a result.
    localparam ert_pkg::t_op OP_UNUSED = 3'd7;

    localparam logic signed [COORD_BITS-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_BITS-1:0] C_MIN = 24'sh800000;
    localparam logic [ert_pkg::EXT_W-1:0]    E_MAX = 23'h7FFFFF;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_start    = 1'b0;
    logic                         o_busy;
    ert_pkg::t_op                 i_op       = ert_pkg::OP_ADD;
    ert_pkg::t_slot               i_slot     = '0;
    logic signed [COORD_BITS-1:0] i_pos_x    = '0;
    logic signed [COORD_BITS-1:0] i_pos_y    = '0;
    logic signed [COORD_BITS-1:0] i_pos_z    = '0;
    logic [ert_pkg::EXT_W-1:0]    i_extent_a = '0;
    logic [ert_pkg::EXT_W-1:0]    i_extent_b = '0;
    logic [ert_pkg::EXT_W-1:0]    i_extent_c = '0;
    logic                         o_valid;
    logic                         o_found;
    ert_pkg::t_slot               o_match_slot;
    logic                         o_last;

    int mismatches;
    int pending;

    // Sender burst bookkeeping: transactions left in the current burst.
    int burst_left;

    // Cluster center for well-formed traffic, kept clear of the wrap point.
    logic signed [COORD_BITS-1:0] hub_x, hub_y, hub_z;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    entity_range_query_table #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_op         (i_op),
        .i_slot       (i_slot),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_extent_a   (i_extent_a),
        .i_extent_b   (i_extent_b),
        .i_extent_c   (i_extent_c),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_match_slot (o_match_slot),
        .o_last       (o_last)
    );

    ert_query_checker #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_op         (i_op),
        .i_slot       (i_slot),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_extent_a   (i_extent_a),
        .i_extent_b   (i_extent_b),
        .i_extent_c   (i_extent_c),
        .i_valid      (o_valid),
        .i_found      (o_found),
        .i_match_slot (o_match_slot),
        .i_last       (o_last),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Issue one transaction and hold it until the block takes it. Keep i_start high
    // across a burst so back-to-back table updates go in every cycle; at the end of a
    // burst drop i_start for a random gap, then pick the next burst length. Now and
    // then a long burst gives a stretch with no idling at all.
    task automatic issue(input ert_pkg::t_op op, input ert_pkg::t_slot slot,
                         input logic signed [COORD_BITS-1:0] x,
                         input logic signed [COORD_BITS-1:0] y,
                         input logic signed [COORD_BITS-1:0] z,
                         input logic [ert_pkg::EXT_W-1:0] a,
                         input logic [ert_pkg::EXT_W-1:0] b,
                         input logic [ert_pkg::EXT_W-1:0] c);
        i_start    <= 1'b1;
        i_op       <= op;
        i_slot     <= slot;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_pos_z    <= z;
        i_extent_a <= a;
        i_extent_b <= b;
        i_extent_c <= c;
        // sample busy as it stood at the edge: the transaction goes in when it is low
        do @(posedge i_clk); while (o_busy);
        burst_left--;
        if (burst_left <= 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(20, 40);
            else
                burst_left = $urandom_range(1, 6);
        end
    endtask

    // Mostly a coordinate near the cluster center; now and then any 24-bit value.
    function automatic logic signed [COORD_BITS-1:0] pick_coord(
            input logic signed [COORD_BITS-1:0] hub);
        if ($urandom_range(0, 3) != 0)
            return hub + COORD_BITS'($urandom_range(0, 2047)) - COORD_BITS'(1024);
        return COORD_BITS'($urandom);
    endfunction

    // Mostly an extent that catches part of the cluster; now and then any value.
    function automatic logic [ert_pkg::EXT_W-1:0] pick_extent();
        if ($urandom_range(0, 4) != 0)
            return ert_pkg::EXT_W'($urandom_range(0, 1500));
        return ert_pkg::EXT_W'($urandom);
    endfunction

    initial begin
        int           sent;
        int           pick;
        ert_pkg::t_op op;
        burst_left = $urandom_range(1, 6);
        hub_x = COORD_BITS'($urandom_range(0, 32'h800000)) - COORD_BITS'(32'h400000);
        hub_y = COORD_BITS'($urandom_range(0, 32'h800000)) - COORD_BITS'(32'h400000);
        hub_z = COORD_BITS'($urandom_range(0, 32'h800000)) - COORD_BITS'(32'h400000);

        // Hold reset, once.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: corners of the fields and the special cases.
        // Query an empty table: expect the single not-found result.
        issue(ert_pkg::OP_RECT,   0,  0, 0, 0, E_MAX, E_MAX, E_MAX);
        issue(ert_pkg::OP_ADD,    0,  0, 0, 0, 0, 0, 0);
        issue(ert_pkg::OP_ADD,    63, C_MAX, C_MAX, C_MAX, 0, 0, 0);
        issue(ert_pkg::OP_ADD,    5,  3, 7, 4, 0, 0, 0);
        // Exact edges: dx = 3, dz = 4 sits right on every inclusive bound.
        issue(ert_pkg::OP_RECT,   0,  0, 0, 0, 3, 4, 0);
        issue(ert_pkg::OP_CIRCLE, 0,  0, 0, 0, 5, 0, 0);
        // Radius 4 passes both axis bounds on slot 5 but fails the squared sum.
        issue(ert_pkg::OP_CIRCLE, 0,  0, 0, 0, 4, 0, 0);
        issue(ert_pkg::OP_CYL,    0,  0, 0, 0, 5, 6, 0);
        issue(ert_pkg::OP_CYL,    0,  0, 0, 0, 5, 7, 0);
        issue(ert_pkg::OP_CUBOID, 0,  0, 0, 0, 3, 4, 6);
        // Full range: from C_MIN no slot is within E_MAX; from C_MAX every live slot is.
        issue(ert_pkg::OP_RECT,   0,  C_MIN, C_MIN, C_MIN, E_MAX, E_MAX, 0);
        issue(ert_pkg::OP_RECT,   0,  C_MAX, C_MAX, C_MAX, E_MAX, E_MAX, 0);
        // Add to a live slot overwrites its position.
        issue(ert_pkg::OP_ADD,    5,  C_MIN, C_MIN, C_MIN, 0, 0, 0);
        // Remove of a dead slot changes nothing.
        issue(ert_pkg::OP_REMOVE, 7,  0, 0, 0, 0, 0, 0);
        // Move of a dead slot writes the position but leaves it dead.
        issue(ert_pkg::OP_MOVE,   9,  100, -100, 50, 0, 0, 0);
        issue(ert_pkg::OP_REMOVE, 0,  0, 0, 0, 0, 0, 0);
        issue(OP_UNUSED,          3,  C_MAX, C_MIN, C_MAX, E_MAX, E_MAX, E_MAX);
        issue(ert_pkg::OP_CUBOID, 0,  C_MIN, C_MIN, C_MIN, 0, 0, 0);
        issue(ert_pkg::OP_CIRCLE, 0,  C_MAX, C_MAX, C_MAX, E_MAX, 0, 0);
        issue(ert_pkg::OP_MOVE,   63, 0, 0, 0, 0, 0, 0);
        issue(ert_pkg::OP_RECT,   0,  0, 0, 0, 0, 0, 0);
        issue(ert_pkg::OP_ADD,    9,  100, -100, 50, 0, 0, 0);
        issue(ert_pkg::OP_CYL,    0,  100, -100, 50, 0, 0, 0);

        // Random part: about half queries around the cluster, the rest table churn
        // that keeps a fair number of slots live, plus a sprinkle of dropped opcodes.
        sent = 0;
        while (sent < ITEM_COUNT) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                op = ert_pkg::OP_ADD;
            else if (pick < 37)
                op = ert_pkg::OP_REMOVE;
            else if (pick < 47)
                op = ert_pkg::OP_MOVE;
            else if (pick < 50)
                op = OP_UNUSED;
            else
                op = ert_pkg::t_op'($urandom_range(ert_pkg::OP_RECT, ert_pkg::OP_CUBOID));
            issue(op, ert_pkg::t_slot'($urandom_range(0, SLOTS - 1)),
                  pick_coord(hub_x), pick_coord(hub_y), pick_coord(hub_z),
                  pick_extent(), pick_extent(), pick_extent());
            if (op != OP_UNUSED)
                sent++;
        end

        // Drain: wait for every expected result, then keep watching for any stray strobe.
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
